### src/hll_pkg.sv
// ----------------------------------------------------------------------------
// HyperLogLog register store package
// Shared constants, operation codes and control types of the sketch block.
// ----------------------------------------------------------------------------
package hll_pkg;

  localparam int HASH_W        = 64;
  localparam int RANK_W        = 6;
  localparam int PREC_W        = 4;
  localparam int EIDX_W        = 14;
  localparam int SUM_W         = 63;
  localparam int ZERO_W        = 15;
  localparam int FRAC_BITS     = 44;
  localparam int LO_SHIFT      = 63 - FRAC_BITS;
  localparam int MIN_PRECISION = 4;
  localparam int IN_DATA_W     = 88;
  localparam int OUT_DATA_W    = 80;

  localparam logic [PREC_W-1:0] PREC_RESET = 4'd14;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_MERGE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef struct packed {
    logic clear;
    logic data_valid;
  } acc_ctl_t;

endpackage

### src/hll_ram.sv
// ----------------------------------------------------------------------------
// HyperLogLog rank memory
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hll_ram #(
  parameter int ADDR_W = 14
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [hll_pkg::RANK_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [hll_pkg::RANK_W-1:0] rd_data
);

  logic [hll_pkg::RANK_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### src/hll_rank.sv
// ----------------------------------------------------------------------------
// HyperLogLog rank pipeline
// Splits a hash into register index and rank over two register stages.
// ----------------------------------------------------------------------------
module hll_hash_split #(
  parameter int MAXP = 14,
  parameter int PW   = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_merge,
  input  logic [hll_pkg::HASH_W-1:0] in_hash,
  input  logic [MAXP-1:0]            in_midx,
  input  logic [hll_pkg::RANK_W-1:0] in_mval,
  input  logic [PW-1:0]              prec,
  output logic                       out_valid,
  output logic [MAXP-1:0]            out_idx,
  output logic [hll_pkg::RANK_W-1:0] out_rank,
  output logic                       busy
);

  logic                       s1_valid_r;
  logic                       s1_merge_r;
  logic [MAXP-1:0]            s1_idx_r;
  logic [hll_pkg::RANK_W-1:0] s1_mval_r;
  logic [hll_pkg::HASH_W-1:0] s1_rest_r;

  logic                       s2_valid_r;
  logic                       s2_merge_r;
  logic [MAXP-1:0]            s2_idx_r;
  logic [hll_pkg::RANK_W-1:0] s2_mval_r;
  logic [7:0]                 s2_nz_r;
  logic [2:0]                 s2_lzb_r [8];

  logic [MAXP-1:0]            hash_top;
  logic [MAXP-1:0]            hash_idx;
  logic [7:0]                 byte_nz;
  logic [2:0]                 byte_lz [8];
  logic [2:0]                 sel;
  logic [hll_pkg::RANK_W-1:0] lz_total;

  assign hash_top = in_hash[hll_pkg::HASH_W-1 -: MAXP];
  assign hash_idx = hash_top >> (PW'(MAXP) - prec);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
    end
    s1_merge_r <= in_merge;
    s1_idx_r   <= in_merge ? in_midx : hash_idx;
    s1_mval_r  <= in_mval;
    s1_rest_r  <= in_hash << prec;
    s2_merge_r <= s1_merge_r;
    s2_idx_r   <= s1_idx_r;
    s2_mval_r  <= s1_mval_r;
    s2_nz_r    <= byte_nz;
    for (int k = 0; k < 8; k++) begin
      s2_lzb_r[k] <= byte_lz[k];
    end
  end

  always_comb begin
    logic [7:0] bits;
    logic       found;
    for (int k = 0; k < 8; k++) begin
      bits       = s1_rest_r[hll_pkg::HASH_W-1-8*k -: 8];
      byte_nz[k] = |bits;
      byte_lz[k] = 3'd0;
      found      = 1'b0;
      for (int b = 7; b >= 0; b--) begin
        if (!found && bits[b]) begin
          byte_lz[k] = 3'(7 - b);
          found      = 1'b1;
        end
      end
    end
  end

  always_comb begin
    sel = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (s2_nz_r[k]) begin
        sel = 3'(k);
      end
    end
    lz_total = {sel, s2_lzb_r[sel]};
  end

  always_comb begin
    if (s2_merge_r) begin
      out_rank = s2_mval_r;
    end else if (|s2_nz_r) begin
      out_rank = lz_total + hll_pkg::RANK_W'(1);
    end else begin
      out_rank = hll_pkg::RANK_W'(7'd65 - 7'(prec));
    end
  end

  assign out_valid = s2_valid_r;
  assign out_idx   = s2_idx_r;
  assign busy      = s1_valid_r | s2_valid_r;

endmodule

### src/hll_acc.sv
// ----------------------------------------------------------------------------
// HyperLogLog harmonic sum accumulator
// Adds two to minus each swept register and counts registers at zero.
// ----------------------------------------------------------------------------
module hll_acc #(
  parameter int MAXP = 14
) (
  input  logic                       clk,
  input  hll_pkg::acc_ctl_t          ctl,
  input  logic [hll_pkg::RANK_W-1:0] rank,
  output logic [hll_pkg::SUM_W-1:0]  sum,
  output logic [MAXP:0]              zeros
);

  localparam int LO_W = MAXP + hll_pkg::LO_SHIFT;

  logic [hll_pkg::SUM_W-1:0] hi_r;
  logic [LO_W-1:0]           lo_r;
  logic [MAXP:0]             zeros_r;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      hi_r    <= '0;
      lo_r    <= '0;
      zeros_r <= '0;
    end else if (ctl.data_valid) begin
      if (rank <= hll_pkg::RANK_W'(hll_pkg::FRAC_BITS)) begin
        hi_r <= hi_r + (hll_pkg::SUM_W'(1) << (hll_pkg::RANK_W'(hll_pkg::FRAC_BITS) - rank));
      end else begin
        lo_r <= lo_r + (LO_W'(1) << (hll_pkg::RANK_W'(63) - rank));
      end
      if (rank == '0) begin
        zeros_r <= zeros_r + (MAXP+1)'(1);
      end
    end
  end

  assign sum   = hi_r + hll_pkg::SUM_W'(lo_r >> hll_pkg::LO_SHIFT);
  assign zeros = zeros_r;

endmodule

### src/hyperloglog_sketch_registers.sv
// ----------------------------------------------------------------------------
// HyperLogLog sketch register store
// Keeps the rank registers of a sketch and answers harmonic sum queries.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Contents
//   in_      slave      operation, hash, entry_index, entry_value
//   out_     master     harmonic_sum, zero_count (one per query)
//   cfg_     slave      precision
//
// Adds and merges are taken one per clock while in_tready is high, through a
// read-modify-write pipeline around the rank RAM, with one forwarding register.
// A clear writes all 2**MAX_PRECISION entries, one per cycle, after the
// pipeline drains; a query reads 2**p entries, one per cycle, then passes
// through ST_TAIL and ST_FIN for the read latency and final sum. After reset
// the same clearing pass runs with in_tready low.
// ----------------------------------------------------------------------------
module hyperloglog_sketch_registers #(
  parameter int MAX_PRECISION = 14
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // operation[1:0], hash[65:2], entry_index[79:66], entry_value[85:80]
  input  logic [hll_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // harmonic_sum[62:0], zero_count[77:63]
  output logic [hll_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hll_pkg::PREC_W-1:0]     cfg_data
);

  localparam int PW = $clog2(MAX_PRECISION + 1);

  typedef enum logic [2:0] {
    ST_RUN,
    ST_DRAIN,
    ST_CLEAR,
    ST_QUERY,
    ST_TAIL,
    ST_FIN
  } state_t;

  state_t                         state_r;
  logic                           pend_clear_r;
  logic [MAX_PRECISION-1:0]       cnt_r;
  logic                           qv_r;
  logic [hll_pkg::PREC_W-1:0]     prec_r;
  logic                           out_valid_r;
  logic [hll_pkg::SUM_W-1:0]      out_sum_r;
  logic [hll_pkg::ZERO_W-1:0]     out_zero_r;

  logic                           s3_valid_r;
  logic [MAX_PRECISION-1:0]       s3_idx_r;
  logic [hll_pkg::RANK_W-1:0]     s3_rank_r;
  logic                           fwd_valid_r;
  logic [MAX_PRECISION-1:0]       fwd_idx_r;
  logic [hll_pkg::RANK_W-1:0]     fwd_data_r;

  hll_pkg::op_t                   in_op;
  logic [hll_pkg::HASH_W-1:0]     in_hash;
  logic [hll_pkg::EIDX_W-1:0]     in_eidx;
  logic [hll_pkg::RANK_W-1:0]     in_eval;
  logic                           in_fire;
  logic                           merge_ok;
  logic                           pipe_in;
  logic [PW-1:0]                  p_act;
  logic [MAX_PRECISION-1:0]       last_idx;
  logic                           pipe_busy;
  logic                           rank_busy;
  logic                           rk_valid;
  logic [MAX_PRECISION-1:0]       rk_idx;
  logic [hll_pkg::RANK_W-1:0]     rk_rank;
  logic [hll_pkg::RANK_W-1:0]     cur_val;
  logic [hll_pkg::RANK_W-1:0]     new_val;
  logic                           ram_we;
  logic [MAX_PRECISION-1:0]       ram_wa;
  logic [hll_pkg::RANK_W-1:0]     ram_wd;
  logic [MAX_PRECISION-1:0]       ram_ra;
  logic [hll_pkg::RANK_W-1:0]     ram_rd;
  hll_pkg::acc_ctl_t              acc_ctl;
  logic [hll_pkg::SUM_W-1:0]      acc_sum;
  logic [MAX_PRECISION:0]         acc_zeros;

  assign in_op   = hll_pkg::op_t'(in_tdata[1:0]);
  assign in_hash = in_tdata[65:2];
  assign in_eidx = in_tdata[79:66];
  assign in_eval = in_tdata[85:80];

  always_comb begin
    if (int'(prec_r) < hll_pkg::MIN_PRECISION) begin
      p_act = PW'(hll_pkg::MIN_PRECISION);
    end else if (int'(prec_r) > MAX_PRECISION) begin
      p_act = PW'(MAX_PRECISION);
    end else begin
      p_act = PW'(prec_r);
    end
  end

  assign last_idx  = ~({MAX_PRECISION{1'b1}} << p_act);
  assign in_tready = (state_r == ST_RUN);
  assign in_fire   = in_tvalid & in_tready;
  assign merge_ok  = ((32'(in_eidx) >> p_act) == 32'd0);
  assign pipe_in   = in_fire & ((in_op == hll_pkg::OP_ADD) ||
                                ((in_op == hll_pkg::OP_MERGE) && merge_ok));
  assign pipe_busy = rank_busy | s3_valid_r;
  assign cfg_ready = 1'b1;

  hll_hash_split #(
    .MAXP (MAX_PRECISION),
    .PW   (PW)
  ) u_rank (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pipe_in),
    .in_merge  (in_op == hll_pkg::OP_MERGE),
    .in_hash   (in_hash),
    .in_midx   (MAX_PRECISION'(in_eidx)),
    .in_mval   (in_eval),
    .prec      (p_act),
    .out_valid (rk_valid),
    .out_idx   (rk_idx),
    .out_rank  (rk_rank),
    .busy      (rank_busy)
  );

  assign cur_val = (fwd_valid_r && (fwd_idx_r == s3_idx_r)) ? fwd_data_r : ram_rd;
  assign new_val = (s3_rank_r > cur_val) ? s3_rank_r : cur_val;

  assign ram_we = (state_r == ST_CLEAR) | s3_valid_r;
  assign ram_wa = (state_r == ST_CLEAR) ? cnt_r : s3_idx_r;
  assign ram_wd = (state_r == ST_CLEAR) ? '0 : new_val;
  assign ram_ra = (state_r == ST_QUERY) ? cnt_r : rk_idx;

  hll_ram #(
    .ADDR_W (MAX_PRECISION)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  assign acc_ctl.clear      = (state_r == ST_DRAIN) & ~pend_clear_r;
  assign acc_ctl.data_valid = qv_r;

  hll_acc #(
    .MAXP (MAX_PRECISION)
  ) u_acc (
    .clk   (clk),
    .ctl   (acc_ctl),
    .rank  (ram_rd),
    .sum   (acc_sum),
    .zeros (acc_zeros)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      pend_clear_r <= 1'b0;
      cnt_r        <= '0;
      qv_r         <= 1'b0;
      prec_r       <= hll_pkg::PREC_RESET;
      out_valid_r  <= 1'b0;
      s3_valid_r   <= 1'b0;
      fwd_valid_r  <= 1'b0;
    end else begin
      qv_r        <= (state_r == ST_QUERY);
      s3_valid_r  <= rk_valid;
      fwd_valid_r <= s3_valid_r;
      if (cfg_valid && cfg_ready) begin
        prec_r <= cfg_data;
      end
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_RUN: begin
          if (in_fire && (in_op == hll_pkg::OP_CLEAR || in_op == hll_pkg::OP_QUERY)) begin
            pend_clear_r <= (in_op == hll_pkg::OP_CLEAR);
            state_r      <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          cnt_r <= '0;
          if (!pipe_busy && pend_clear_r) begin
            state_r <= ST_CLEAR;
          end else if (!pipe_busy && !out_valid_r) begin
            state_r <= ST_QUERY;
          end
        end
        ST_CLEAR: begin
          cnt_r <= cnt_r + MAX_PRECISION'(1);
          if (cnt_r == {MAX_PRECISION{1'b1}}) begin
            state_r <= ST_RUN;
          end
        end
        ST_QUERY: begin
          cnt_r <= cnt_r + MAX_PRECISION'(1);
          if (cnt_r == last_idx) begin
            state_r <= ST_TAIL;
          end
        end
        ST_TAIL: begin
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          out_valid_r <= 1'b1;
          state_r     <= ST_RUN;
        end
        default: begin
          state_r <= ST_RUN;
        end
      endcase
    end
    s3_idx_r   <= rk_idx;
    s3_rank_r  <= rk_rank;
    fwd_idx_r  <= s3_idx_r;
    fwd_data_r <= new_val;
    if (state_r == ST_FIN) begin
      out_sum_r  <= acc_sum;
      out_zero_r <= hll_pkg::ZERO_W'(acc_zeros);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_zero_r, out_sum_r};

endmodule
